// ===== hdl/fsg_pkg.sv =====
`default_nettype none
package fsg_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam logic [7:0] WALL_VALUE = 8'd255;

   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int Y_BITS      = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS   = X_BITS + Y_BITS;
   localparam int CELL_COUNT  = MAX_WIDTH * MAX_HEIGHT;
   localparam int COORD_BITS  = ((X_BITS > Y_BITS) ? X_BITS : Y_BITS) + 2;
   localparam int CSR_BITS    = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [X_BITS:0]               wdim_type;
   typedef logic [Y_BITS:0]               hdim_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic signed [COORD_BITS-1:0]  coord_type;
   typedef logic signed [1:0]             step_type;

   typedef enum logic [1:0] {
      FN_WRITE = 2'd0,
      FN_READ  = 2'd1,
      FN_STEP  = 2'd2,
      FN_NONE  = 2'd3
   } func_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_SEED   = 3'd2,
      CSR_CAP    = 3'd3,
      CSR_SLIP   = 3'd4
   } csr_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         pos_x;
      logic [7:0]         pos_y;
      logic [7:0]         cell_in;
      logic signed [15:0] grav_x;
      logic signed [15:0] grav_y;
      logic [7:0]         jostle;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_value;
      logic       step_done;
   } rsp_type;

   function automatic logic [31:0] xorshift(input logic [31:0] s);
      logic [31:0] v;
      v = s ^ (s << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   function automatic wdim_type eff_width(input logic [8:0] v);
      if (v == 9'd0) begin
         return wdim_type'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         return wdim_type'(MAX_WIDTH);
      end
      return wdim_type'(v);
   endfunction

   function automatic hdim_type eff_height(input logic [8:0] v);
      if (v == 9'd0) begin
         return hdim_type'(1);
      end else if (32'(v) > MAX_HEIGHT) begin
         return hdim_type'(MAX_HEIGHT);
      end
      return hdim_type'(v);
   endfunction

   function automatic logic inside_grid(input coord_type cx, input coord_type cy,
                                        input wdim_type w, input hdim_type h);
      coord_type sw;
      coord_type sh;
      sw = coord_type'(w);
      sh = coord_type'(h);
      return (cx >= 0) && (cx < sw) && (cy >= 0) && (cy < sh);
   endfunction

   function automatic addr_type cell_addr(input coord_type cx, input coord_type cy);
      return {cy[Y_BITS-1:0], cx[X_BITS-1:0]};
   endfunction

   function automatic step_type sgn16(input logic signed [15:0] v);
      if (v > 0) begin
         return 2'sd1;
      end else if (v < 0) begin
         return -2'sd1;
      end
      return 2'sd0;
   endfunction

   function automatic step_type ring_dx(input logic [2:0] ix);
      step_type d;
      unique case (ix)
         3'd1, 3'd2, 3'd3: d = 2'sd1;
         3'd5, 3'd6, 3'd7: d = -2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic step_type ring_dy(input logic [2:0] ix);
      step_type d;
      unique case (ix)
         3'd0, 3'd1, 3'd7: d = 2'sd1;
         3'd3, 3'd4, 3'd5: d = -2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic [2:0] dir_code(input step_type dx, input step_type dy);
      logic [2:0] ix;
      ix = 3'd7;
      for (int i = 0; i < 7; i++) begin
         if (ix == 3'd7 && ring_dx(3'(i)) == dx && ring_dy(3'(i)) == dy) begin
            ix = 3'(i);
         end
      end
      return ix;
   endfunction

   function automatic logic signed [17:0] scale(input step_type m,
                                                input logic signed [15:0] g);
      logic signed [17:0] r;
      if (m > 0) begin
         r = 18'(g);
      end else if (m < 0) begin
         r = -18'(g);
      end else begin
         r = 18'sd0;
      end
      return r;
   endfunction

   function automatic logic driven(input logic [2:0] ix, input logic signed [15:0] gx,
                                   input logic signed [15:0] gy);
      logic signed [17:0] descent;
      logic signed [17:0] lateral;
      logic [17:0]        lat_abs;
      logic [21:0]        lhs;
      logic [21:0]        rhs;
      descent = scale(ring_dx(ix), gx) + scale(ring_dy(ix), gy);
      lateral = scale(ring_dx(ix), gy) - scale(ring_dy(ix), gx);
      lat_abs = lateral[17] ? 18'(-lateral) : 18'(lateral);
      lhs = 22'(descent[16:0]) * 22'd10;
      rhs = 22'(lat_abs) * 22'd7;
      return (descent > 0) && (lhs > rhs);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/falling_sand_grid_step_top.sv =====
// Falling-sand grid stepper.
// Input beats arrive on req_* (valid/ready) and each produces exactly one
// result beat on rsp_*. A beat writes a cell, reads a cell, runs one
// simulation step over the whole grid, or does nothing; csr_* writes the
// size, seed, load cap and slip chance registers, and must only be used
// while the block is idle (the block itself does not enforce this).
// A write answers straight from the result register; an in-grid read
// waits for the registered memory read. A step runs set-up states (divider,
// weight, direction, drive), then visits every cell of the grid; its length
// is set by the grid memory, with one write and one registered read port.
// One beat is handled at a time; the next beat is taken as soon as the
// result register is free or being emptied in the same cycle.
// After reset the grid memory is cleared one cell per cycle, and req_ready
// stays low during that pass. When rsp_ready is low the result holds in its
// register and no new beat is accepted until it has been taken.
`default_nettype none
module falling_sand_grid_step_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  fsg_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output fsg_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_wr_en,
   input  wire [fsg_pkg::CSR_BITS-1:0]          csr_index,
   input  wire [fsg_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import fsg_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RD_WAIT, S_DIV, S_WT1, S_WT2, S_DIR, S_DRV,
      S_CELL_RD, S_CELL_CHK, S_RNG, S_TRY, S_TRY_CHK, S_TRY_CLR,
      S_LOAD_CHK, S_LOAD_WAIT, S_ALLOW, S_NEXT
   } state_type;

   typedef enum logic [2:0] {
      PH_FALL_A, PH_FALL_B, PH_FIRST, PH_SECOND, PH_FALL_C
   } phase_type;

   logic [7:0] grid_mem [CELL_COUNT];
   logic [7:0] rd_data_ff;
   addr_type   rd_addr;
   logic       wr_en;
   addr_type   wr_addr;
   logic [7:0] wr_data;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   addr_type           clr_ff, clr_in;
   logic [8:0]         width_ff, width_in, height_ff, height_in;
   logic [3:0]         cap_ff, cap_in;
   logic [7:0]         slip_ff, slip_in;
   logic [31:0]        rng_ff, rng_in;
   logic               flip_ff, flip_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic signed [15:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [7:0]         jostle_ff, jostle_in;
   logic [16:0]        rem_ff, rem_in;
   logic [8:0]         quo_ff, quo_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [14:0]        prod_ff, prod_in;
   logic [8:0]         wt_ff, wt_in;
   logic [2:0]         fall_ix_ff, fall_ix_in, a_ix_ff, a_ix_in, b_ix_ff, b_ix_in;
   step_type           ld_x_ff, ld_x_in, ld_y_ff, ld_y_in;
   logic               a_drv_ff, a_drv_in, b_drv_ff, b_drv_in;
   logic               x_rev_ff, x_rev_in, y_rev_ff, y_rev_in;
   logic [X_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [Y_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [7:0]         grain_ff, grain_in;
   logic [31:0]        r_ff, r_in;
   logic               shaken_ff, shaken_in;
   logic [3:0]         load_n_ff, load_n_in;

   wdim_type           w_eff;
   hdim_type           h_eff;
   logic [15:0]        ax, ay, lo, hi;
   logic [16:0]        div_t;
   logic               div_ge;
   logic [21:0]        wt_mul;
   logic [31:0]        rng_nx;
   step_type           sx, sy, mv_x, mv_y;
   logic [2:0]         mv_ix;
   logic               mv_en;
   coord_type          cx, cy, tx, ty, lx, ly, loff;
   logic               x_last, y_last;
   logic [7:0]         slip_c, allow;
   state_type          fail_state;
   phase_type          fail_phase;
   logic               accept;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   assign w_eff = eff_width(width_ff);
   assign h_eff = eff_height(height_ff);
   assign ax = gx_ff[15] ? 16'(-gx_ff) : 16'(gx_ff);
   assign ay = gy_ff[15] ? 16'(-gy_ff) : 16'(gy_ff);
   assign lo = (ax < ay) ? ax : ay;
   assign hi = (ax < ay) ? ay : ax;
   assign sx = sgn16(gx_ff);
   assign sy = sgn16(gy_ff);
   assign div_t = (cnt_ff == 4'd0) ? {1'b0, lo} : {rem_ff[15:0], 1'b0};
   assign div_ge = div_t >= {1'b0, hi};
   assign wt_mul = 22'(prod_ff) * 22'd89;
   assign rng_nx = xorshift(rng_ff);

   assign cx = coord_type'({1'b0, cur_x_ff});
   assign cy = coord_type'({1'b0, cur_y_ff});

   always_comb begin
      unique case (phase_ff)
         PH_FIRST: begin
            mv_ix = r_ff[0] ? a_ix_ff : b_ix_ff;
            mv_en = r_ff[0] ? a_drv_ff : b_drv_ff;
         end
         PH_SECOND: begin
            mv_ix = r_ff[0] ? b_ix_ff : a_ix_ff;
            mv_en = r_ff[0] ? b_drv_ff : a_drv_ff;
         end
         default: begin
            mv_ix = fall_ix_ff;
            mv_en = 1'b1;
         end
      endcase
   end

   assign mv_x = ring_dx(mv_ix);
   assign mv_y = ring_dy(mv_ix);
   assign tx = cx + coord_type'(mv_x);
   assign ty = cy + coord_type'(mv_y);

   assign loff = coord_type'({1'b0, load_n_ff} + 5'd1);
   assign lx = (ld_x_ff > 0) ? cx - loff : ((ld_x_ff < 0) ? cx + loff : cx);
   assign ly = (ld_y_ff > 0) ? cy - loff : ((ld_y_ff < 0) ? cy + loff : cy);

   assign x_last = x_rev_ff ? (cur_x_ff == '0)
                            : ({1'b0, cur_x_ff} == w_eff - wdim_type'(1));
   assign y_last = y_rev_ff ? (cur_y_ff == '0)
                            : ({1'b0, cur_y_ff} == h_eff - hdim_type'(1));

   assign slip_c = (load_n_ff >= cap_ff) ? 8'd0 : (slip_ff >> (load_n_ff - 4'd1));
   assign allow = (slip_c > jostle_ff) ? slip_c : jostle_ff;

   always_comb begin
      fail_phase = phase_ff;
      unique case (phase_ff)
         PH_FALL_A: fail_state = S_RNG;
         PH_FALL_B: fail_state = S_LOAD_CHK;
         PH_FIRST: begin
            fail_state = S_TRY;
            fail_phase = PH_SECOND;
         end
         PH_SECOND: begin
            if (shaken_ff) begin
               fail_state = S_TRY;
               fail_phase = PH_FALL_C;
            end else begin
               fail_state = S_NEXT;
            end
         end
         default: fail_state = S_NEXT;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      clr_in = clr_ff;
      width_in = width_ff;
      height_in = height_ff;
      cap_in = cap_ff;
      slip_in = slip_ff;
      rng_in = rng_ff;
      flip_in = flip_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      jostle_in = jostle_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      wt_in = wt_ff;
      fall_ix_in = fall_ix_ff;
      a_ix_in = a_ix_ff;
      b_ix_in = b_ix_ff;
      ld_x_in = ld_x_ff;
      ld_y_in = ld_y_ff;
      a_drv_in = a_drv_ff;
      b_drv_in = b_drv_ff;
      x_rev_in = x_rev_ff;
      y_rev_in = y_rev_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      grain_in = grain_ff;
      r_in = r_ff;
      shaken_in = shaken_ff;
      load_n_in = load_n_ff;
      rd_addr = cell_addr(cx, cy);
      wr_en = 1'b0;
      wr_addr = cell_addr(tx, ty);
      wr_data = grain_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'd0;
            clr_in = clr_ff + addr_type'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rsp_data_in = '0;
               gx_in = req_data.grav_x;
               gy_in = req_data.grav_y;
               jostle_in = req_data.jostle;
               cnt_in = 4'd0;
               unique case (func_type'(req_data.func))
                  FN_WRITE: begin
                     rsp_valid_in = 1'b1;
                     wr_addr = cell_addr(coord_type'({1'b0, req_data.pos_x}),
                                         coord_type'({1'b0, req_data.pos_y}));
                     wr_data = req_data.cell_in;
                     wr_en = inside_grid(coord_type'({1'b0, req_data.pos_x}),
                                         coord_type'({1'b0, req_data.pos_y}),
                                         w_eff, h_eff);
                  end
                  FN_READ: begin
                     rd_addr = cell_addr(coord_type'({1'b0, req_data.pos_x}),
                                         coord_type'({1'b0, req_data.pos_y}));
                     if (inside_grid(coord_type'({1'b0, req_data.pos_x}),
                                     coord_type'({1'b0, req_data.pos_y}),
                                     w_eff, h_eff)) begin
                        state_in = S_RD_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.cell_value = WALL_VALUE;
                     end
                  end
                  FN_STEP: begin
                     if (req_data.grav_x == 16'sd0 && req_data.grav_y == 16'sd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.step_done = 1'b1;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.cell_value = rd_data_ff;
            state_in = S_IDLE;
         end
         S_DIV: begin
            rem_in = div_ge ? div_t - {1'b0, hi} : div_t;
            quo_in = {quo_ff[7:0], div_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               state_in = S_WT1;
            end
         end
         S_WT1: begin
            prod_in = 15'(18'(quo_ff) * 18'(9'd256 - quo_ff));
            state_in = S_WT2;
         end
         S_WT2: begin
            wt_in = quo_ff + {3'b000, wt_mul[21:16]};
            state_in = S_DIR;
         end
         S_DIR: begin
            rng_in = rng_nx;
            if ({1'b0, rng_nx[7:0]} < wt_ff) begin
               fall_ix_in = dir_code(sx, sy);
            end else if (ax > ay) begin
               fall_ix_in = dir_code(sx, 2'sd0);
            end else begin
               fall_ix_in = dir_code(2'sd0, sy);
            end
            if (21'(ay) * 21'd12 > 21'(ax) * 21'd29) begin
               ld_x_in = 2'sd0;
               ld_y_in = sy;
            end else if (21'(ax) * 21'd12 > 21'(ay) * 21'd29) begin
               ld_x_in = sx;
               ld_y_in = 2'sd0;
            end else begin
               ld_x_in = sx;
               ld_y_in = sy;
            end
            state_in = S_DRV;
         end
         S_DRV: begin
            a_ix_in = fall_ix_ff + 3'd7;
            b_ix_in = fall_ix_ff + 3'd1;
            a_drv_in = driven(fall_ix_ff + 3'd7, gx_ff, gy_ff);
            b_drv_in = driven(fall_ix_ff + 3'd1, gx_ff, gy_ff);
            x_rev_in = (ring_dx(fall_ix_ff) > 0) || (ring_dx(fall_ix_ff) == 0 && flip_ff);
            y_rev_in = ring_dy(fall_ix_ff) > 0;
            cur_x_in = x_rev_in ? X_BITS'(w_eff - wdim_type'(1)) : '0;
            cur_y_in = y_rev_in ? Y_BITS'(h_eff - hdim_type'(1)) : '0;
            flip_in = !flip_ff;
            state_in = S_CELL_RD;
         end
         S_CELL_RD: begin
            state_in = S_CELL_CHK;
         end
         S_CELL_CHK: begin
            grain_in = rd_data_ff;
            load_n_in = 4'd0;
            if (rd_data_ff == 8'd0) begin
               state_in = S_NEXT;
            end else if (jostle_ff == 8'd0) begin
               phase_in = PH_FALL_A;
               state_in = S_TRY;
            end else begin
               state_in = S_RNG;
            end
         end
         S_RNG: begin
            rng_in = rng_nx;
            r_in = rng_nx;
            shaken_in = (jostle_ff != 8'd0) && (rng_nx[15:8] < jostle_ff);
            if (!shaken_in && jostle_ff != 8'd0) begin
               phase_in = PH_FALL_B;
               state_in = S_TRY;
            end else begin
               state_in = S_LOAD_CHK;
            end
         end
         S_TRY: begin
            rd_addr = cell_addr(tx, ty);
            if (mv_en && inside_grid(tx, ty, w_eff, h_eff)) begin
               state_in = S_TRY_CHK;
            end else begin
               state_in = fail_state;
               phase_in = fail_phase;
            end
         end
         S_TRY_CHK: begin
            if (rd_data_ff == 8'd0) begin
               wr_en = 1'b1;
               state_in = S_TRY_CLR;
            end else begin
               state_in = fail_state;
               phase_in = fail_phase;
            end
         end
         S_TRY_CLR: begin
            wr_en = 1'b1;
            wr_addr = cell_addr(cx, cy);
            wr_data = 8'd0;
            state_in = S_NEXT;
         end
         S_LOAD_CHK: begin
            rd_addr = cell_addr(lx, ly);
            if (load_n_ff >= cap_ff || !inside_grid(lx, ly, w_eff, h_eff)) begin
               state_in = S_ALLOW;
            end else begin
               state_in = S_LOAD_WAIT;
            end
         end
         S_LOAD_WAIT: begin
            if (rd_data_ff == 8'd0) begin
               state_in = S_ALLOW;
            end else begin
               load_n_in = load_n_ff + 4'd1;
               state_in = S_LOAD_CHK;
            end
         end
         S_ALLOW: begin
            if (load_n_ff == 4'd0 || r_ff[23:16] < allow) begin
               phase_in = PH_FIRST;
               state_in = S_TRY;
            end else if (shaken_ff) begin
               phase_in = PH_FALL_C;
               state_in = S_TRY;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            state_in = S_CELL_RD;
            if (!x_last) begin
               cur_x_in = x_rev_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end else if (!y_last) begin
               cur_y_in = y_rev_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
               cur_x_in = x_rev_ff ? X_BITS'(w_eff - wdim_type'(1)) : '0;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in.cell_value = 8'd0;
               rsp_data_in.step_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         unique case (csr_type'(csr_index))
            CSR_WIDTH:  width_in = csr_wdata[8:0];
            CSR_HEIGHT: height_in = csr_wdata[8:0];
            CSR_SEED:   rng_in = (csr_wdata == '0) ? 32'd1 : csr_wdata;
            CSR_CAP:    cap_in = csr_wdata[3:0];
            CSR_SLIP:   slip_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         cap_ff <= 4'd4;
         slip_ff <= 8'd128;
         rng_ff <= 32'd1;
         flip_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PH_FALL_A;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         width_ff <= width_in;
         height_ff <= height_in;
         cap_ff <= cap_in;
         slip_ff <= slip_in;
         rng_ff <= rng_in;
         flip_ff <= flip_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;
      end
      rsp_data_ff <= rsp_data_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      jostle_ff <= jostle_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      wt_ff <= wt_in;
      fall_ix_ff <= fall_ix_in;
      a_ix_ff <= a_ix_in;
      b_ix_ff <= b_ix_in;
      ld_x_ff <= ld_x_in;
      ld_y_ff <= ld_y_in;
      a_drv_ff <= a_drv_in;
      b_drv_ff <= b_drv_in;
      x_rev_ff <= x_rev_in;
      y_rev_ff <= y_rev_in;
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      grain_ff <= grain_in;
      r_ff <= r_in;
      shaken_ff <= shaken_in;
      load_n_ff <= load_n_in;
   end

endmodule
`default_nettype wire

// ===== tb/sv/fsg_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module fsg_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_ready,
   input  fsg_pkg::req_type                 req_data,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  fsg_pkg::rsp_type                 rsp_data,
   input  wire                              csr_wr_en,
   input  wire [fsg_pkg::CSR_BITS-1:0]      csr_index,
   input  wire [fsg_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   import fsg_pkg::*;

   logic [7:0]  sand [0:65535];
   logic [31:0] prng;
   logic        flip;
   int          cols_reg;
   int          rows_reg;
   int          cap_reg;
   int          slip_reg;
   rsp_type     awaited [$];

   int ring_x [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
   int ring_y [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

   function automatic int span(input int v, input int top);
      if (v == 0) begin
         return 1;
      end
      return (v > top) ? top : v;
   endfunction

   function automatic bit in_grid(input int x, input int y, input int w, input int h);
      return x >= 0 && x < w && y >= 0 && y < h;
   endfunction

   function automatic logic [31:0] draw();
      logic [31:0] v;
      v = prng;
      v = v ^ (v << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      prng = v;
      return v;
   endfunction

   function automatic bit shift_grain(input int x, input int y, input int mx, input int my,
                                      input int w, input int h, input logic [7:0] g);
      int nx;
      int ny;
      nx = x + mx;
      ny = y + my;
      if (!in_grid(nx, ny, w, h) || sand[ny * 256 + nx] != 0) begin
         return 0;
      end
      sand[ny * 256 + nx] = g;
      sand[y * 256 + x] = 0;
      return 1;
   endfunction

   function automatic bit pushes(input int mx, input int my, input int gx, input int gy);
      longint descent;
      longint lateral;
      descent = longint'(mx) * gx + longint'(my) * gy;
      lateral = longint'(mx) * gy - longint'(my) * gx;
      if (descent <= 0) begin
         return 0;
      end
      if (lateral < 0) begin
         lateral = -lateral;
      end
      return descent * 10 > lateral * 7;
   endfunction

   function automatic int load_count(input int x, input int y, input int lx, input int ly,
                                     input int w, input int h);
      int n;
      int cx;
      int cy;
      n = 0;
      cx = x - lx;
      cy = y - ly;
      while (n < cap_reg) begin
         if (!in_grid(cx, cy, w, h) || sand[cy * 256 + cx] == 0) begin
            break;
         end
         n++;
         cx -= lx;
         cy -= ly;
      end
      return n;
   endfunction

   function automatic int slide_allowance(input int load, input int jo);
      int c;
      if (load == 0) begin
         return 256;
      end
      c = (load >= cap_reg) ? 0 : (slip_reg >> (load - 1));
      return (c > jo) ? c : jo;
   endfunction

   function automatic void run_frame(input int gx, input int gy, input int jo);
      int w, h, ax, ay, sx, sy, lo, hi, rr, wt, dx, dy, lx, ly, i;
      int ax0, ay0, bx0, by0, y0, y1, ys, x0, x1, xs, x, y;
      int fx, fy, sx2, sy2, allow;
      bit a_drv, b_drv, f_drv, s_drv, shaken;
      logic [7:0]  g;
      logic [31:0] r;
      w = span(cols_reg, MAX_WIDTH);
      h = span(rows_reg, MAX_HEIGHT);
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      sx = (gx > 0) ? 1 : ((gx < 0) ? -1 : 0);
      sy = (gy > 0) ? 1 : ((gy < 0) ? -1 : 0);
      if (ax == 0 && ay == 0) begin
         return;
      end
      lo = (ax < ay) ? ax : ay;
      hi = (ax < ay) ? ay : ax;
      rr = (lo * 256) / hi;
      wt = rr + ((89 * rr * (256 - rr)) >> 16);
      if (int'(draw() & 32'hFF) < wt) begin
         dx = sx;
         dy = sy;
      end else if (ax > ay) begin
         dx = sx;
         dy = 0;
      end else begin
         dx = 0;
         dy = sy;
      end
      if (ay * 12 > ax * 29) begin
         lx = 0;
         ly = sy;
      end else if (ax * 12 > ay * 29) begin
         lx = sx;
         ly = 0;
      end else begin
         lx = sx;
         ly = sy;
      end
      for (i = 0; i < 7; i++) begin
         if (ring_x[i] == dx && ring_y[i] == dy) begin
            break;
         end
      end
      ax0 = ring_x[(i + 7) & 7];
      ay0 = ring_y[(i + 7) & 7];
      bx0 = ring_x[(i + 1) & 7];
      by0 = ring_y[(i + 1) & 7];
      a_drv = pushes(ax0, ay0, gx, gy);
      b_drv = pushes(bx0, by0, gx, gy);
      if (dy > 0) begin
         y0 = h - 1; y1 = -1; ys = -1;
      end else begin
         y0 = 0; y1 = h; ys = 1;
      end
      if (dx > 0 || (dx == 0 && flip)) begin
         x0 = w - 1; x1 = -1; xs = -1;
      end else begin
         x0 = 0; x1 = w; xs = 1;
      end
      flip = !flip;
      for (y = y0; y != y1; y += ys) begin
         for (x = x0; x != x1; x += xs) begin
            g = sand[y * 256 + x];
            if (g == 0) begin
               continue;
            end
            if (jo == 0 && shift_grain(x, y, dx, dy, w, h, g)) begin
               continue;
            end
            r = draw();
            if (r[0]) begin
               fx = ax0; fy = ay0; f_drv = a_drv;
               sx2 = bx0; sy2 = by0; s_drv = b_drv;
            end else begin
               fx = bx0; fy = by0; f_drv = b_drv;
               sx2 = ax0; sy2 = ay0; s_drv = a_drv;
            end
            shaken = jo > 0 && int'(r[15:8]) < jo;
            if (!shaken && jo > 0 && shift_grain(x, y, dx, dy, w, h, g)) begin
               continue;
            end
            allow = slide_allowance(load_count(x, y, lx, ly, w, h), jo);
            if (allow >= 256 || int'(r[23:16]) < allow) begin
               if (f_drv && shift_grain(x, y, fx, fy, w, h, g)) begin
                  continue;
               end
               if (s_drv && shift_grain(x, y, sx2, sy2, w, h, g)) begin
                  continue;
               end
            end
            if (shaken) begin
               void'(shift_grain(x, y, dx, dy, w, h, g));
            end
         end
      end
   endfunction

   function automatic rsp_type predict_beat(input req_type b);
      rsp_type o;
      int w;
      int h;
      w = span(cols_reg, MAX_WIDTH);
      h = span(rows_reg, MAX_HEIGHT);
      o = '0;
      case (func_type'(b.func))
         FN_WRITE: begin
            if (in_grid(b.pos_x, b.pos_y, w, h)) begin
               sand[int'(b.pos_y) * 256 + int'(b.pos_x)] = b.cell_in;
            end
         end
         FN_READ: begin
            o.cell_value = in_grid(b.pos_x, b.pos_y, w, h) ?
                           sand[int'(b.pos_y) * 256 + int'(b.pos_x)] : WALL_VALUE;
         end
         FN_STEP: begin
            run_frame(int'(b.grav_x), int'(b.grav_y), int'(b.jostle));
            o.step_done = 1'b1;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 65536; i++) begin
            sand[i] = 8'd0;
         end
         prng = 32'd1;
         flip = 1'b0;
         cols_reg = 256;
         rows_reg = 256;
         cap_reg = 4;
         slip_reg = 128;
         awaited.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_type'(csr_index))
               CSR_WIDTH:  cols_reg = int'(csr_wdata[8:0]);
               CSR_HEIGHT: rows_reg = int'(csr_wdata[8:0]);
               CSR_SEED:   prng = (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
               CSR_CAP:    cap_reg = int'(csr_wdata[3:0]);
               CSR_SLIP:   slip_reg = int'(csr_wdata[7:0]);
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got %h", $time,
                        rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited.pop_front();
               if (rsp_data.cell_value !== want.cell_value ||
                   rsp_data.step_done !== want.step_done) begin
                  $display("%0t: result mismatch, expected value %0d done %0d, got value %0d done %0d",
                           $time, want.cell_value, want.step_done, rsp_data.cell_value,
                           rsp_data.step_done);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited.push_back(predict_beat(req_data));
         end
         pending <= awaited.size();
      end
   end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import fsg_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [CSR_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int      fail_count;
   int      pending;
   bit      quiet;
   bit      hold_long;

   falling_sand_grid_step_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   fsg_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #400ms;
      $display("** falling_sand_grid_step_top: FAILED **");
      $finish;
   end

   // The receiver stalls in short bursts, and once for a long stretch so that the
   // block backs up and holds off the sender.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_long = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!reset && !quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input req_type b);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
   endtask

   task automatic set_reg(input csr_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic setup(input int w, input int h, input logic [31:0] seed,
                        input int cap, input int slip);
      set_reg(CSR_WIDTH, w);
      set_reg(CSR_HEIGHT, h);
      set_reg(CSR_SEED, seed);
      set_reg(CSR_CAP, cap);
      set_reg(CSR_SLIP, slip);
   endtask

   function automatic req_type cell_beat(input func_type f, input int x, input int y,
                                         input int v);
      req_type b;
      b = '0;
      b.func = f;
      b.pos_x = 8'(x);
      b.pos_y = 8'(y);
      b.cell_in = 8'(v);
      return b;
   endfunction

   function automatic req_type step_beat(input int gx, input int gy, input int jo);
      req_type b;
      b = '0;
      b.func = FN_STEP;
      b.grav_x = 16'(gx);
      b.grav_y = 16'(gy);
      b.jostle = 8'(jo);
      return b;
   endfunction

   function automatic req_type random_beat(input int w, input int h);
      req_type b;
      int pick;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      b = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         b.func = FN_WRITE;
         b.pos_x = 8'($urandom_range(0, w - 1));
         b.pos_y = 8'($urandom_range(0, h - 1));
      end else if (pick < 50) begin
         b.func = FN_WRITE;
      end else if (pick < 72) begin
         b.func = FN_READ;
         b.pos_x = 8'($urandom_range(0, w - 1));
         b.pos_y = 8'($urandom_range(0, h - 1));
      end else if (pick < 78) begin
         b.func = FN_READ;
      end else if (pick < 95) begin
         b.func = FN_STEP;
         case ($urandom_range(0, 7))
            0: begin
               b.grav_x = '0;
               b.grav_y = '0;
            end
            1: begin
               b.grav_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               b.grav_y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            default: begin
            end
         endcase
         if ($urandom_range(0, 1) == 0) begin
            b.jostle = '0;
         end
      end else begin
         b.func = FN_NONE;
      end
      return b;
   endfunction

   task automatic random_run(input int count, input int w, input int h);
      for (int i = 0; i < count; i++) begin
         send_beat(random_beat(w, h));
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 1'b0;
      hold_long = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      setup(8, 8, 32'h1234_5678, 4, 128);
      send_beat(cell_beat(FN_WRITE, 3, 0, 1));
      send_beat(cell_beat(FN_WRITE, 3, 1, 2));
      send_beat(cell_beat(FN_WRITE, 4, 0, 255));
      send_beat(cell_beat(FN_WRITE, 7, 7, 9));
      send_beat(cell_beat(FN_WRITE, 8, 0, 5));
      send_beat(cell_beat(FN_WRITE, 255, 255, 7));
      send_beat(cell_beat(FN_READ, 3, 0, 0));
      send_beat(cell_beat(FN_READ, 255, 255, 0));
      send_beat(cell_beat(FN_READ, 8, 0, 0));
      send_beat(cell_beat(FN_NONE, 1, 1, 1));
      send_beat(step_beat(0, 0, 0));
      send_beat(step_beat(0, 32767, 0));
      send_beat(step_beat(-32768, 0, 0));
      send_beat(step_beat(1000, 1000, 255));
      send_beat(step_beat(-32768, -32768, 1));
      send_beat(step_beat(300, -20000, 128));
      send_beat(step_beat(-5, 12, 0));
      send_beat(cell_beat(FN_READ, 3, 7, 0));
      send_beat(cell_beat(FN_READ, 4, 7, 0));
      send_beat(cell_beat(FN_READ, 0, 0, 0));
      send_beat(cell_beat(FN_READ, 7, 7, 0));
      send_beat(cell_beat(FN_READ, 0, 7, 0));
      drain();

      setup(8, 8, $urandom, 4, 128);
      random_run(30, 8, 8);
      setup(1, 16, 32'd0, 0, 255);
      random_run(15, 1, 16);
      setup(0, 300, 32'hFFFF_FFFF, 15, 0);
      random_run(15, 1, 256);
      setup(511, 2, $urandom, 1, $urandom_range(0, 255));
      random_run(10, 256, 2);

      setup(6, 6, $urandom, $urandom_range(1, 15), $urandom_range(0, 255));
      hold_long = 1'b1;
      random_run(20, 6, 6);

      quiet = 1'b1;
      setup(256, 256, $urandom, 4, 128);
      send_beat(cell_beat(FN_WRITE, 255, 255, 3));
      send_beat(cell_beat(FN_WRITE, 0, 0, 4));
      send_beat(cell_beat(FN_WRITE, 128, 10, 5));
      send_beat(step_beat(-700, 9000, 0));
      send_beat(cell_beat(FN_READ, 255, 255, 0));
      send_beat(cell_beat(FN_READ, 0, 1, 0));
      send_beat(cell_beat(FN_READ, 128, 11, 0));
      drain();
      repeat (50) @(negedge clock);

      if (fail_count == 0) begin
         $display("** falling_sand_grid_step_top: PASSED **");
      end else begin
         $display("** falling_sand_grid_step_top: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== falling_sand_grid_step_top.f =====
hdl/fsg_pkg.sv
hdl/falling_sand_grid_step_top.sv
tb/sv/fsg_checker.sv
tb/sv/tb_top.sv
